/* hw/rtl/pqre_pkg.sv */
// Package for the palette quantizer / run-length encoder.
// Holds the word types, action codes, sequencer states and default sizes.
// No dependencies.
package pqre_pkg;

  localparam int unsigned MAX_SITES_DEF = 256;
  localparam int unsigned INDEX_SPAN    = 256;
  localparam int unsigned DIST_W        = 18;
  localparam int unsigned COLOR_W       = 24;
  localparam logic [7:0]  RUN_LIMIT     = 8'hFF;
  localparam logic [8:0]  SITES_RESET   = 9'd256;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic [7:0] run_length;
    logic [7:0] site_index;
  } run_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/palette_quantizer_rle_encoder_top.sv */
// Palette quantizer with run-length coding of the chosen palette indices.
// Depends on pqre_pkg and pqre_ram.
//
// Usage:
//   item channel (item_valid / item_stall / item): load, pixel or flush words.
//   run channel (run_valid / run_stall / run): (run_length, site_index) words.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): active_sites register,
//   always ready; write it only while the block is idle.
// Operation:
//   A load word is written without leaving idle. A flush goes to the emit
//   step. A pixel searches N entries, N = active_sites clamped to 1..min(256,
//   MAX_SITES): one distance unit walks the palette RAM one entry per cycle
//   through a read / distance / compare pipeline. item_stall is high while a
//   word is in progress. A pixel or flush gives at most one run word.
// Output:
//   The run word sits in an output register; the next item is taken while
//   it waits. If a new run word is due while the register is still held by
//   run_stall, the block waits in its emit step until the register frees.
// Reset (rst, synchronous): no run open, active_sites = 256, output empty.
//   Palette contents are undefined until loaded.
module palette_quantizer_rle_encoder_top #(
  parameter int unsigned MAX_SITES = pqre_pkg::MAX_SITES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  pqre_pkg::item_t     item,
  output logic                run_valid,
  input  logic                run_stall,
  output pqre_pkg::run_t      run,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          cfg_data
);

  localparam int unsigned DEPTH = (MAX_SITES < pqre_pkg::INDEX_SPAN) ?
                                  MAX_SITES : pqre_pkg::INDEX_SPAN;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = pqre_pkg::DIST_W;

  pqre_pkg::state_t state, state_next;

  logic [8:0]    active_sites;
  logic [CW-1:0] limit;
  logic [CW-1:0] limit_next;
  logic [CW-1:0] scan_cnt;
  logic          is_flush;
  logic [7:0]    pix_r, pix_g, pix_b;

  logic          s1_valid, s2_valid;
  logic [AW-1:0] s1_idx, s2_idx;
  logic [DW-1:0] s2_dist;
  logic [AW-1:0] best_idx;
  logic [DW-1:0] best_dist;

  logic [7:0]    run_site;
  logic [7:0]    run_count;
  logic          run_open;

  logic          accept;
  logic          load_we;
  logic          issue;
  logic          scan_done;
  logic [pqre_pkg::COLOR_W-1:0] rdata;
  logic [DW-1:0] cand_dist;
  logic [7:0]    new_site;
  logic          emit_run;
  logic          out_free;
  logic          emit_load;
  logic          emit_done;

  assign accept    = item_valid && !item_stall;
  assign item_stall = (state != pqre_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign load_we   = accept && (item.action == pqre_pkg::ACT_LOAD) &&
                     (32'(item.entry_index) < DEPTH);
  assign issue     = (state == pqre_pkg::ST_SCAN) && (scan_cnt < limit);
  assign scan_done = !issue && !s1_valid && !s2_valid;
  assign new_site  = 8'(best_idx);

  pqre_ram #(
    .WIDTH (pqre_pkg::COLOR_W),
    .DEPTH (DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (load_we),
    .waddr (item.entry_index[AW-1:0]),
    .wdata ({item.red, item.green, item.blue}),
    .re    (issue),
    .raddr (scan_cnt[AW-1:0]),
    .rdata (rdata)
  );

  // distance unit: sum of squared channel differences
  always_comb begin
    logic [7:0]  dr, dg, db;
    logic [15:0] qr, qg, qb;
    dr = (pix_r > rdata[23:16]) ? pix_r - rdata[23:16] : rdata[23:16] - pix_r;
    dg = (pix_g > rdata[15:8])  ? pix_g - rdata[15:8]  : rdata[15:8]  - pix_g;
    db = (pix_b > rdata[7:0])   ? pix_b - rdata[7:0]   : rdata[7:0]   - pix_b;
    qr = dr * dr;
    qg = dg * dg;
    qb = db * db;
    cand_dist = DW'(qr) + DW'(qg) + DW'(qb);
  end

  always_comb begin
    if (active_sites == 9'd0) begin
      limit_next = CW'(1);
    end else if (32'(active_sites) >= DEPTH) begin
      limit_next = CW'(DEPTH);
    end else begin
      limit_next = CW'(active_sites);
    end
  end

  assign out_free = !run_valid || !run_stall;

  always_comb begin
    state_next = state;
    emit_run   = 1'b0;
    emit_load  = 1'b0;
    emit_done  = 1'b0;
    unique case (state)
      pqre_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (item.action)
            pqre_pkg::ACT_PIXEL: state_next = pqre_pkg::ST_SCAN;
            pqre_pkg::ACT_FLUSH: state_next = pqre_pkg::ST_EMIT;
            default:             state_next = pqre_pkg::ST_IDLE;
          endcase
        end
      end
      pqre_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = pqre_pkg::ST_EMIT;
        end
      end
      pqre_pkg::ST_EMIT: begin
        if (is_flush) begin
          emit_run = run_open;
        end else begin
          emit_run = run_open &&
                     ((new_site != run_site) || (run_count >= pqre_pkg::RUN_LIMIT));
        end
        if (!emit_run || out_free) begin
          emit_load  = emit_run;
          emit_done  = 1'b1;
          state_next = pqre_pkg::ST_IDLE;
        end
      end
      default: state_next = pqre_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pqre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sites <= pqre_pkg::SITES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_sites <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r    <= item.red;
      pix_g    <= item.green;
      pix_b    <= item.blue;
      is_flush <= (item.action == pqre_pkg::ACT_FLUSH);
      limit    <= limit_next;
      scan_cnt <= '0;
    end else if (issue) begin
      scan_cnt <= scan_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= scan_cnt[AW-1:0];
    s2_idx  <= s1_idx;
    s2_dist <= cand_dist;
    if (s2_valid && ((s2_idx == '0) || (s2_dist < best_dist))) begin
      best_idx  <= s2_idx;
      best_dist <= s2_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open  <= 1'b0;
      run_site  <= '0;
      run_count <= '0;
    end else if (emit_done) begin
      if (is_flush) begin
        run_open  <= 1'b0;
        run_site  <= '0;
        run_count <= '0;
      end else if (run_open && !emit_run) begin
        run_count <= run_count + 8'd1;
      end else begin
        run_open  <= 1'b1;
        run_site  <= new_site;
        run_count <= 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (emit_load) begin
      run_valid <= 1'b1;
    end else if (!run_stall) begin
      run_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      run.run_length <= run_count;
      run.site_index <= run_site;
    end
  end

endmodule

/* hw/rtl/pqre_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pqre_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pqre_checker.sv */
// Port-level checker for palette_quantizer_rle_encoder_top, with its bind.
// Depends on pqre_pkg.
module pqre_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_stall,
  input pqre_pkg::item_t item,
  input logic            run_valid,
  input logic            run_stall,
  input pqre_pkg::run_t  run,
  input logic            cfg_valid,
  input logic            cfg_ready,
  input logic [8:0]      cfg_data
);

  // a pixel keeps the block busy at the start of its search
  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (item.action == pqre_pkg::ACT_PIXEL)
    |=> item_stall ##1 item_stall)
    else $error("pixel word did not hold the item channel busy");

  // a load leaves the item channel free in the cycle after it is taken
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (item.action == pqre_pkg::ACT_LOAD)
    |=> !item_stall)
    else $error("load word kept the item channel busy");

  a_run_hold: assert property (@(posedge clk) disable iff (rst)
    run_valid && run_stall |=> run_valid && $stable(run))
    else $error("stalled run word changed or dropped");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (run.run_length != 8'd0))
    else $error("run word with zero length");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !run_valid && !item_stall)
    else $error("block not empty after reset");

endmodule

bind palette_quantizer_rle_encoder_top pqre_checker u_pqre_checker (.*);

/* verif/pqre_run_checker.sv */
// Run-word checker for the palette quantizer / run-length encoder.
// Watches the item, run and cfg channels, predicts run words and compares them.
// Depends on pqre_pkg.
module pqre_run_checker
  import pqre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_stall,
  input  item_t      item,
  input  logic       run_valid,
  input  logic       run_stall,
  input  run_t       run,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [8:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  logic [23:0] colors [INDEX_SPAN];
  logic [8:0]  sites;
  logic [7:0]  open_site;
  logic [7:0]  open_count;
  logic        open_flag;
  run_t        runs_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    for (int k = 0; k < INDEX_SPAN; k++) colors[k] = '0;
  end

  function automatic logic [7:0] closest_site(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int lim;
    int best;
    int best_d;
    int d;
    int dr;
    int dg;
    int db;
    lim = sites;
    if (lim < 1) lim = 1;
    if (lim > INDEX_SPAN) lim = INDEX_SPAN;
    best   = 0;
    best_d = 0;
    for (int k = 0; k < lim; k++) begin
      dr = int'(r) - int'(colors[k][23:16]);
      dg = int'(g) - int'(colors[k][15:8]);
      db = int'(b) - int'(colors[k][7:0]);
      d  = dr * dr + dg * dg + db * db;
      if (k == 0 || d < best_d) begin
        best_d = d;
        best   = k;
      end
    end
    return best[7:0];
  endfunction

  always @(posedge clk) begin
    logic [7:0] site;
    run_t       want;
    if (rst) begin
      sites      = SITES_RESET;
      open_site  = '0;
      open_count = '0;
      open_flag  = 1'b0;
      runs_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) sites = cfg_data;

      if (run_valid && !run_stall) begin
        if (runs_due.size() == 0) begin
          fail_count++;
          $display("%0t unexpected run word: expected none, got len %0d site %0d",
                   $time, run.run_length, run.site_index);
        end else begin
          want = runs_due.pop_front();
          if (run.run_length !== want.run_length || run.site_index !== want.site_index) begin
            fail_count++;
            $display("%0t run word mismatch: expected len %0d site %0d, got len %0d site %0d",
                     $time, want.run_length, want.site_index, run.run_length, run.site_index);
          end
        end
      end

      if (item_valid && !item_stall) begin
        case (item.action)
          ACT_LOAD: begin
            colors[item.entry_index] = {item.red, item.green, item.blue};
          end
          ACT_PIXEL: begin
            site = closest_site(item.red, item.green, item.blue);
            if (open_flag && (site != open_site || open_count >= RUN_LIMIT)) begin
              runs_due.push_back('{run_length: open_count, site_index: open_site});
              open_flag = 1'b0;
            end
            if (open_flag) begin
              open_count = open_count + 8'd1;
            end else begin
              open_flag  = 1'b1;
              open_site  = site;
              open_count = 8'd1;
            end
          end
          ACT_FLUSH: begin
            if (open_flag) runs_due.push_back('{run_length: open_count, site_index: open_site});
            open_flag  = 1'b0;
            open_site  = '0;
            open_count = '0;
          end
          default: ;
        endcase
      end
    end
    pending = runs_due.size();
  end

endmodule

/* verif/palette_quantizer_rle_encoder_top_tb.sv */
// Testbench top for palette_quantizer_rle_encoder_top: clock, reset, stimulus, verdict.
// Depends on pqre_pkg, the block and pqre_run_checker.
module palette_quantizer_rle_encoder_top_tb;
  import pqre_pkg::*;

  localparam logic [1:0] ACT_SPARE   = 2'd3;
  localparam int         SETTLE      = 300;
  localparam int         HOLD_CYCLES = 400;
  localparam int         LIMIT       = 1_500_000;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       item_valid = 1'b0;
  item_t      item       = '0;
  logic       run_stall  = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic [8:0] cfg_data   = '0;
  logic       item_stall;
  logic       run_valid;
  run_t       run;
  logic       cfg_ready;
  int         fail_count;
  int         pending;

  int          send_idle = 14;
  int          recv_idle = 73;
  int          hold_req  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycles    = 0;
  int          sites_now = 256;
  logic [23:0] shade [INDEX_SPAN];
  logic [23:0] last_px = '0;

  always #5 clk = ~clk;

  palette_quantizer_rle_encoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .run_valid  (run_valid),
    .run_stall  (run_stall),
    .run        (run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  pqre_run_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .run_valid  (run_valid),
    .run_stall  (run_stall),
    .run        (run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(negedge clk) begin
    if (hold_left > 0) begin
      run_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      run_stall <= 1'b1;
    end else begin
      run_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // entered and left at a falling edge; valid stays high for a back-to-back word
  task automatic send_word(logic [1:0] action, logic [7:0] idx, logic [23:0] rgb);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{action: action, entry_index: idx,
              red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0]};
    if (action == ACT_LOAD) shade[idx] = rgb;
    if (action == ACT_PIXEL) last_px = rgb;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_sites(logic [8:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    sites_now = (v < 1) ? 1 : (v > INDEX_SPAN) ? INDEX_SPAN : v;
  endtask

  task automatic run_phase(int s_idle, int r_idle);
    int          a;
    int          c;
    logic [23:0] rgb;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int seg = 0; seg < 3; seg++) begin
      wait_idle();
      case ($urandom_range(9))
        0:       write_sites(9'd0);
        1:       write_sites(9'd1);
        2:       write_sites(9'd2);
        7:       write_sites(9'($urandom_range(17, 64)));
        8:       write_sites(9'd256);
        9:       write_sites(9'($urandom_range(257, 511)));
        default: write_sites(9'($urandom_range(3, 16)));
      endcase
      for (int k = 0; k < 6; k++) begin
        a   = $urandom_range(99);
        rgb = 24'($urandom);
        if (a < 12) begin
          send_word(ACT_LOAD, 8'($urandom), rgb);
        end else if (a < 19) begin
          send_word(ACT_FLUSH, 8'($urandom), rgb);
        end else if (a < 22) begin
          send_word(ACT_SPARE, 8'($urandom), rgb);
        end else begin
          c = $urandom_range(99);
          if (c < 45) rgb = last_px;
          else if (c < 75) rgb = shade[$urandom_range(sites_now - 1)] ^ (24'($urandom) & 24'h030303);
          send_word(ACT_PIXEL, 8'($urandom), rgb);
        end
      end
    end
  endtask

  initial begin
    int          order [INDEX_SPAN];
    int          j;
    int          t;
    for (int k = 0; k < INDEX_SPAN; k++) begin
      shade[k] = '0;
      order[k] = k;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty flush, unused action, ties, extremes
    send_word(ACT_FLUSH, 8'hFF, 24'hFFFFFF);
    send_word(ACT_SPARE, 8'hFF, 24'hFFFFFF);
    send_word(ACT_LOAD, 8'd0, 24'h000000);
    send_word(ACT_LOAD, 8'd1, 24'h020000);
    send_word(ACT_LOAD, 8'd2, 24'hFFFFFF);
    send_word(ACT_LOAD, 8'd3, 24'hFFFFFF);
    wait_idle();
    write_sites(9'd4);
    send_word(ACT_PIXEL, 8'h00, 24'h010000);
    send_word(ACT_PIXEL, 8'hFF, 24'hFFFFFF);
    send_word(ACT_PIXEL, 8'h00, 24'hFEFFFF);
    send_word(ACT_PIXEL, 8'h00, 24'h020000);
    send_word(ACT_FLUSH, 8'h00, 24'h000000);
    send_word(ACT_FLUSH, 8'h00, 24'h000000);
    wait_idle();
    write_sites(9'd0);
    send_word(ACT_PIXEL, 8'h00, 24'hFFFFFF);
    send_word(ACT_PIXEL, 8'h00, 24'h000000);
    send_word(ACT_FLUSH, 8'h00, 24'h000000);

    // fill the whole palette in shuffled order
    for (int k = INDEX_SPAN - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < INDEX_SPAN; k++) send_word(ACT_LOAD, 8'(order[k]), 24'($urandom));
    wait_idle();
    write_sites(9'd511);
    send_word(ACT_PIXEL, 8'h00, shade[255]);
    send_word(ACT_PIXEL, 8'h00, 24'h808080);
    send_word(ACT_FLUSH, 8'h00, 24'h000000);
    wait_idle();
    write_sites(9'd256);
    send_word(ACT_PIXEL, 8'h00, 24'($urandom));
    send_word(ACT_FLUSH, 8'h00, 24'h000000);

    // long receiver hold-off with a new run word per pixel
    wait_idle();
    write_sites(9'd4);
    send_word(ACT_LOAD, 8'd0, 24'h000000);
    send_word(ACT_LOAD, 8'd1, 24'hFF0000);
    send_word(ACT_LOAD, 8'd2, 24'h00FF00);
    send_word(ACT_LOAD, 8'd3, 24'h0000FF);
    hold_req++;
    for (int k = 0; k < 12; k++) send_word(ACT_PIXEL, 8'h00, shade[k % 4]);
    send_word(ACT_FLUSH, 8'h00, 24'h000000);
    wait_idle();

    run_phase(14, 73);
    run_phase(73, 14);
    run_phase(0, 0);

    // run that hits the length limit
    wait_idle();
    write_sites(9'd1);
    for (int k = 0; k < 257; k++) send_word(ACT_PIXEL, 8'($urandom), 24'($urandom));
    send_word(ACT_FLUSH, 8'h00, 24'h000000);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
